[design/htc_pkg.sv]
package htc_pkg;

	localparam int FRAC_BITS_DEF = 24;
	localparam int PIPE_DEPTH = 6;

	localparam logic [5:0] ASCII_ZERO = 6'd48;
	localparam logic [13:0] TEMP_SHOWN_MAX = 14'd9999;
	localparam logic [9:0] HUM_SHOWN_MAX = 10'd999;
	localparam logic [9:0] HUM_TENTHS_MAX = 10'd1000;
	localparam logic [9:0] HUM_TENTHS_MIN = 10'd1;

	typedef enum logic [1:0] {
		TEMP_OK   = 2'd0,
		TEMP_LOW  = 2'd1,
		TEMP_HIGH = 2'd2
	} temp_range_t;

	typedef enum logic [1:0] {
		HUM_OK   = 2'd0,
		HUM_HIGH = 2'd1,
		HUM_LOW  = 2'd2
	} humid_clamp_t;

	// floor(x / 10), exact for x < 43690
	function automatic logic [13:0] div10(input logic [13:0] x);
		logic [29:0] p;
		p = 30'(x) * 30'd52429;
		return 14'(p >> 19);
	endfunction

	function automatic logic [5:0] digit_char(input logic [3:0] d);
		return ASCII_ZERO + 6'(d);
	endfunction

endpackage

[design/htc_humid.sv]
module htc_humid import htc_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic [PIPE_DEPTH-1:0] ld,
	input  logic [13:0]           raw_temp,
	input  logic [11:0]           raw_humid,
	output logic [9:0]            humid_tenths,
	output logic [5:0]            humid_tens_char,
	output logic [5:0]            humid_ones_char,
	output logic [5:0]            humid_frac_char,
	output humid_clamp_t          humid_clamp
);

	localparam longint ONE_Q = longint'(1) <<< FRAC_BITS;
	localparam longint C2Q = (405 * ONE_Q + 5000) / 10000;
	localparam longint C3Q = (28 * ONE_Q + 5000000) / 10000000;
	localparam longint T1Q = (ONE_Q + 50) / 100;
	localparam longint T2Q = (8 * ONE_Q + 50000) / 100000;

	localparam int CW = FRAC_BITS;       // coefficient width
	localparam int PW = FRAC_BITS + 12;  // coefficient * h
	localparam int KW = FRAC_BITS + 1;   // slope of temperature term
	localparam int QW = FRAC_BITS + 24;  // C3 * h^2
	localparam int LW = FRAC_BITS + 10;  // linearized humidity, signed
	localparam int SW = FRAC_BITS + 17;  // 100 * rh, signed

	localparam logic [CW-1:0] C2Q_V = CW'(C2Q);
	localparam logic [CW-1:0] C3Q_V = CW'(C3Q);
	localparam logic [CW-1:0] T1Q_V = CW'(T1Q);
	localparam logic [CW-1:0] T2Q_V = CW'(T2Q);
	localparam logic signed [LW-1:0] C1Q_V = LW'(-4 * ONE_Q);
	localparam logic signed [SW-1:0] S_HI = SW'(10000 * ONE_Q);
	localparam logic signed [SW-1:0] S_LO = SW'(10 * ONE_Q);

	// stage 1: products of h
	logic [23:0]        hsq_s1;
	logic [PW-1:0]      t2h_s1;
	logic [PW-1:0]      c2h_s1;
	logic signed [14:0] dt_s1;

	always_ff @(posedge clk) begin
		if (ld[0]) begin
			hsq_s1 <= 24'(raw_humid) * 24'(raw_humid);
			t2h_s1 <= PW'(T2Q_V) * PW'(raw_humid);
			c2h_s1 <= PW'(C2Q_V) * PW'(raw_humid);
			dt_s1  <= $signed({1'b0, raw_temp}) - 15'sd6500;  // (t - 25) in hundredths
		end
	end

	// stage 2: slope, linear part, square term
	logic [KW-1:0]        k_s2;
	logic signed [LW-1:0] lin1_s2;
	logic [QW-1:0]        c3hh_s2;
	logic signed [14:0]   dt_s2;

	always_ff @(posedge clk) begin
		if (ld[1]) begin
			k_s2    <= KW'(T1Q_V) + KW'(t2h_s1);
			lin1_s2 <= C1Q_V + $signed(LW'(c2h_s1));
			c3hh_s2 <= QW'(C3Q_V) * QW'(hsq_s1);
			dt_s2   <= dt_s1;
		end
	end

	// stage 3: temperature term, full linearization
	logic signed [SW-1:0] prod_c;
	logic signed [SW-1:0] prod_s3;
	logic signed [LW-1:0] lin_s3;

	assign prod_c = SW'(dt_s2) * SW'($signed({1'b0, k_s2}));

	always_ff @(posedge clk) begin
		if (ld[2]) begin
			prod_s3 <= prod_c;
			lin_s3  <= lin1_s2 - $signed(LW'(c3hh_s2));
		end
	end

	// stage 4: S = prod + 100 * lin
	logic signed [SW-1:0] lin_x;
	logic signed [SW-1:0] s_s4;

	assign lin_x = SW'(lin_s3);

	always_ff @(posedge clk) begin
		if (ld[3]) begin
			s_s4 <= prod_s3 + (lin_x <<< 6) + (lin_x <<< 5) + (lin_x <<< 2);
		end
	end

	// stage 5: clamp and truncate to tenths
	logic [13:0]  whole;
	logic [13:0]  q10;
	logic [9:0]   tenths_c;
	humid_clamp_t clamp_c;
	logic [9:0]   tenths_s5;
	humid_clamp_t clamp_s5;

	assign whole = s_s4[FRAC_BITS+13:FRAC_BITS];
	assign q10 = div10(whole);

	always_comb begin
		if (s_s4 >= S_HI) begin
			tenths_c = HUM_TENTHS_MAX;
			clamp_c  = HUM_HIGH;
		end else if (s_s4 < S_LO) begin
			tenths_c = HUM_TENTHS_MIN;
			clamp_c  = HUM_LOW;
		end else begin
			tenths_c = q10[9:0];
			clamp_c  = HUM_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (ld[4]) begin
			tenths_s5 <= tenths_c;
			clamp_s5  <= clamp_c;
		end
	end

	// stage 6: digits of the shown value
	logic [9:0]  hshown;
	logic [13:0] h10;
	logic [16:0] h100p;
	logic [3:0]  hd2;
	logic [3:0]  hd1;
	logic [3:0]  hd0;

	assign hshown = (tenths_s5 > HUM_SHOWN_MAX) ? HUM_SHOWN_MAX : tenths_s5;
	assign h10    = div10(14'(hshown));
	assign h100p  = 17'(hshown) * 17'd41;    // /100 for values below 1000
	assign hd2    = h100p[15:12];
	assign hd1    = 4'(h10[6:0] - 7'(hd2) * 7'd10);
	assign hd0    = 4'(hshown - 10'(h10) * 10'd10);

	logic [9:0]   tenths_s6;
	logic [5:0]   tens_s6;
	logic [5:0]   ones_s6;
	logic [5:0]   frac_s6;
	humid_clamp_t clamp_s6;

	always_ff @(posedge clk) begin
		if (ld[5]) begin
			tenths_s6 <= tenths_s5;
			tens_s6   <= digit_char(hd2);
			ones_s6   <= digit_char(hd1);
			frac_s6   <= digit_char(hd0);
			clamp_s6  <= clamp_s5;
		end
	end

	assign humid_tenths    = tenths_s6;
	assign humid_tens_char = tens_s6;
	assign humid_ones_char = ones_s6;
	assign humid_frac_char = frac_s6;
	assign humid_clamp     = clamp_s6;

endmodule

[design/humidity_temp_compensate_digits.sv]
// Channel   Dir  Bits  Payload (lowest bits first)
// s_axis    in   32    raw_temp[13:0], raw_humid[25:14]
// m_axis    out  72    temp_centi, temp digits x4, temp_range, humid_tenths,
//                      humid digits x3, humid_clamp
//
// Six-stage pipeline, one item per cycle sustained unless m_axis_tready stalls
// the output. Nothing iterates, so only an m_axis_tready stall slows the input.
// Each stage holds its own valid bit; a stage loads when it is empty or the
// stage after it moves, so bubbles close up under an output stall.
// arst_n clears the valid bits only; data registers carry no reset.
module humidity_temp_compensate_digits import htc_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // raw_temp[13:0], raw_humid[25:14], zero pad
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata    // temp_centi[14:0], temp_tens_char[20:15],
	                                    // temp_ones_char[26:21], temp_tenths_char[32:27],
	                                    // temp_hundredths_char[38:33], temp_range[40:39],
	                                    // humid_tenths[50:41], humid_tens_char[56:51],
	                                    // humid_ones_char[62:57], humid_frac_char[68:63],
	                                    // humid_clamp[70:69], zero pad
);

	typedef struct packed {
		logic signed [14:0] centi;
		logic [5:0]         tens;
		logic [5:0]         ones;
		logic [5:0]         tenths;
		logic [5:0]         hund;
		temp_range_t        range;
	} temp_out_t;

	logic [13:0] raw_temp;
	logic [11:0] raw_humid;

	assign raw_temp  = s_axis_tdata[13:0];
	assign raw_humid = s_axis_tdata[25:14];

	// ---- flow control: per-stage valid, ready ripples back ----
	logic [PIPE_DEPTH-1:0] vld_q;
	logic [PIPE_DEPTH-1:0] ld;

	always_comb begin
		ld[PIPE_DEPTH-1] = ~vld_q[PIPE_DEPTH-1] | m_axis_tready;
		for (int i = PIPE_DEPTH - 2; i >= 0; i--) begin
			ld[i] = ~vld_q[i] | ld[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (ld[0]) begin
				vld_q[0] <= s_axis_tvalid;
			end
			for (int i = 1; i < PIPE_DEPTH; i++) begin
				if (ld[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
		end
	end

	assign s_axis_tready = ld[0];
	assign m_axis_tvalid = vld_q[PIPE_DEPTH-1];

	// ---- temperature, stage 1: offset and display saturation ----
	logic signed [14:0] tc_c;
	logic [13:0]        tshown_c;
	temp_range_t        trange_c;

	assign tc_c = $signed({1'b0, raw_temp}) - 15'sd4000;

	always_comb begin
		if (tc_c < 15'sd0) begin
			tshown_c = '0;
			trange_c = TEMP_LOW;
		end else if (tc_c > $signed({1'b0, TEMP_SHOWN_MAX})) begin
			tshown_c = TEMP_SHOWN_MAX;
			trange_c = TEMP_HIGH;
		end else begin
			tshown_c = tc_c[13:0];
			trange_c = TEMP_OK;
		end
	end

	logic signed [14:0] tc_s1;
	logic [13:0]        tshown_s1;
	temp_range_t        trange_s1;

	always_ff @(posedge clk) begin
		if (ld[0]) begin
			tc_s1     <= tc_c;
			tshown_s1 <= tshown_c;
			trange_s1 <= trange_c;
		end
	end

	// ---- stage 2: quotients by 10, 100, 1000 (reciprocal multiplies) ----
	logic [26:0] q100p;
	logic [26:0] q1000p;

	assign q100p  = 27'(tshown_s1) * 27'd5243;    // >> 19
	assign q1000p = 27'(tshown_s1) * 27'd8389;    // >> 23

	logic signed [14:0] tc_s2;
	logic [13:0]        tshown_s2;
	logic [9:0]         q10_s2;
	logic [6:0]         q100_s2;
	logic [3:0]         q1000_s2;
	temp_range_t        trange_s2;

	always_ff @(posedge clk) begin
		if (ld[1]) begin
			tc_s2     <= tc_s1;
			tshown_s2 <= tshown_s1;
			q10_s2    <= 10'(div10(tshown_s1));
			q100_s2   <= q100p[25:19];
			q1000_s2  <= q1000p[26:23];
			trange_s2 <= trange_s1;
		end
	end

	// ---- stage 3: digits by back-subtraction ----
	logic [3:0] td0;
	logic [3:0] td1;
	logic [3:0] td2;

	assign td0 = 4'(tshown_s2 - 14'(q10_s2) * 14'd10);
	assign td1 = 4'(q10_s2 - 10'(q100_s2) * 10'd10);
	assign td2 = 4'(q100_s2 - 7'(q1000_s2) * 7'd10);

	temp_out_t temp_s3;
	temp_out_t temp_s4;
	temp_out_t temp_s5;
	temp_out_t temp_s6;

	always_ff @(posedge clk) begin
		if (ld[2]) begin
			temp_s3.centi  <= tc_s2;
			temp_s3.tens   <= digit_char(q1000_s2);
			temp_s3.ones   <= digit_char(td2);
			temp_s3.tenths <= digit_char(td1);
			temp_s3.hund   <= digit_char(td0);
			temp_s3.range  <= trange_s2;
		end
	end

	// temperature waits for the humidity path
	always_ff @(posedge clk) begin
		if (ld[3]) begin
			temp_s4 <= temp_s3;
		end
		if (ld[4]) begin
			temp_s5 <= temp_s4;
		end
		if (ld[5]) begin
			temp_s6 <= temp_s5;
		end
	end

	// ---- humidity path ----
	logic [9:0]   humid_tenths;
	logic [5:0]   humid_tens_char;
	logic [5:0]   humid_ones_char;
	logic [5:0]   humid_frac_char;
	humid_clamp_t humid_clamp;

	htc_humid #(
		.FRAC_BITS(FRAC_BITS)
	) u_humid (
		.clk            (clk),
		.ld             (ld),
		.raw_temp       (raw_temp),
		.raw_humid      (raw_humid),
		.humid_tenths   (humid_tenths),
		.humid_tens_char(humid_tens_char),
		.humid_ones_char(humid_ones_char),
		.humid_frac_char(humid_frac_char),
		.humid_clamp    (humid_clamp)
	);

	assign m_axis_tdata = {1'b0, humid_clamp, humid_frac_char, humid_ones_char,
		humid_tens_char, humid_tenths, temp_s6.range, temp_s6.hund,
		temp_s6.tenths, temp_s6.ones, temp_s6.tens, temp_s6.centi};

endmodule

[design/htc_chk.sv]
module htc_chk import htc_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [71:0] m_axis_tdata
);

	logic [14:0] t_centi;
	logic [5:0]  t_tens;
	logic [5:0]  t_ones;
	logic [5:0]  t_tenths;
	logic [5:0]  t_hund;
	logic [1:0]  t_range;
	logic [9:0]  h_tenths;
	logic [5:0]  h_tens;
	logic [5:0]  h_ones;
	logic [5:0]  h_frac;
	logic [1:0]  h_clamp;
	logic [15:0] t_val;
	logic [11:0] h_val;

	assign t_centi  = m_axis_tdata[14:0];
	assign t_tens   = m_axis_tdata[20:15];
	assign t_ones   = m_axis_tdata[26:21];
	assign t_tenths = m_axis_tdata[32:27];
	assign t_hund   = m_axis_tdata[38:33];
	assign t_range  = m_axis_tdata[40:39];
	assign h_tenths = m_axis_tdata[50:41];
	assign h_tens   = m_axis_tdata[56:51];
	assign h_ones   = m_axis_tdata[62:57];
	assign h_frac   = m_axis_tdata[68:63];
	assign h_clamp  = m_axis_tdata[70:69];

	assign t_val = 16'(t_tens - ASCII_ZERO) * 16'd1000 + 16'(t_ones - ASCII_ZERO) * 16'd100
		+ 16'(t_tenths - ASCII_ZERO) * 16'd10 + 16'(t_hund - ASCII_ZERO);
	assign h_val = 12'(h_tens - ASCII_ZERO) * 12'd100 + 12'(h_ones - ASCII_ZERO) * 12'd10
		+ 12'(h_frac - ASCII_ZERO);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed under stall");

	// in-range temperature: digits spell temp_centi
	a_temp_digits: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && t_range == TEMP_OK |-> t_val == {1'b0, t_centi})
		else $error("temperature digits disagree with value");

	// below zero: negative value, digits 00.00
	a_temp_low: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && t_range == TEMP_LOW |-> t_centi[14] && t_val == 16'd0)
		else $error("below-zero temperature shown wrong");

	// unclamped humidity: digits spell humid_tenths
	a_hum_digits: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && h_clamp == HUM_OK |-> h_val == {2'b00, h_tenths})
		else $error("humidity digits disagree with value");

	// clamped humidity values
	a_hum_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && h_clamp != HUM_OK |->
		(h_clamp == HUM_HIGH && h_tenths == HUM_TENTHS_MAX && h_val == 12'd999) ||
		(h_clamp == HUM_LOW && h_tenths == HUM_TENTHS_MIN && h_val == 12'd1))
		else $error("clamped humidity shown wrong");

endmodule

bind humidity_temp_compensate_digits htc_chk u_chk (.*);
